FILE: src/adsr_pkg.sv
package adsr_pkg;

  // Envelope stage codes as they appear on the stage output.
  typedef enum logic [2:0] {
    STAGE_ATTACK  = 3'd0,
    STAGE_DECAY   = 3'd1,
    STAGE_SUSTAIN = 3'd2,
    STAGE_RELEASE = 3'd3,
    STAGE_KILLED  = 3'd4
  } stage_t;

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RATE_COEFF     = 3'd0,
    REG_ATTACK_TARGET  = 3'd1,
    REG_DECAY_TARGET   = 3'd2,
    REG_SUSTAIN_LEVEL  = 3'd3,
    REG_RELEASE_TARGET = 3'd4
  } reg_idx_t;

endpackage

FILE: src/adsr_step.sv
module adsr_step import adsr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        gate,
  input  logic [FRAC_BITS:0]          cur_level,
  input  stage_t                      cur_stage,
  input  logic [FRAC_BITS-1:0]        rate_coeff,
  input  logic [FRAC_BITS:0]          attack_target,
  input  logic signed [FRAC_BITS+1:0] decay_target,
  input  logic [FRAC_BITS:0]          sustain_level,
  input  logic signed [FRAC_BITS+1:0] release_target,
  output logic [FRAC_BITS:0]          next_level,
  output stage_t                      next_stage
);

  localparam int TW = FRAC_BITS + 2;          // target width
  localparam int DW = FRAC_BITS + 3;          // target minus level
  localparam int PW = DW + FRAC_BITS + 1;     // exact product
  localparam int VW = FRAC_BITS + 4;          // stepped level

  localparam logic signed [VW-1:0] ONE_V =
    {{(VW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [VW-1:0] ZERO_V = '0;

  logic signed [TW-1:0] target;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] step;
  logic signed [VW-1:0] level_v;
  logic signed [VW-1:0] stepped;
  logic signed [VW-1:0] sus_raw;
  logic signed [VW-1:0] sus_v;
  logic signed [VW-1:0] result_v;

  // A low gate always aims at the release target; otherwise decay aims
  // at its own target and every other stage uses the attack target.
  always_comb begin
    priority if (!gate) begin
      target = release_target;
    end else if (cur_stage == STAGE_DECAY) begin
      target = decay_target;
    end else begin
      target = signed'({1'b0, attack_target});
    end
  end

  assign level_v = signed'({{(VW-FRAC_BITS-1){1'b0}}, cur_level});
  assign diff    = DW'(target) - signed'({2'b00, cur_level});
  assign prod    = signed'({1'b0, rate_coeff}) * diff;
  // Arithmetic shift of the exact product rounds toward minus infinity.
  assign step    = prod[PW-1:FRAC_BITS];
  assign stepped = level_v + step;

  assign sus_raw = signed'({{(VW-FRAC_BITS-1){1'b0}}, sustain_level});
  assign sus_v   = (sus_raw > ONE_V) ? ONE_V : sus_raw;

  always_comb begin
    result_v   = level_v;
    next_stage = cur_stage;
    if (gate) begin
      unique case (cur_stage)
        STAGE_ATTACK: begin
          result_v = stepped;
          if (stepped >= ONE_V) begin
            result_v   = ONE_V;
            next_stage = STAGE_DECAY;
          end
        end
        STAGE_DECAY: begin
          result_v = stepped;
          if (stepped <= sus_v) begin
            result_v   = sus_v;
            next_stage = STAGE_SUSTAIN;
          end else if (stepped > ONE_V) begin
            result_v = ONE_V;
          end
        end
        default: begin
          // Sustain holds, and release and killed ignore a high gate.
        end
      endcase
    end else if (cur_stage != STAGE_KILLED) begin
      result_v   = stepped;
      next_stage = STAGE_RELEASE;
      if (stepped < ZERO_V) begin
        result_v   = ZERO_V;
        next_stage = STAGE_KILLED;
      end else if (stepped > ONE_V) begin
        result_v = ONE_V;
      end
    end
  end

  assign next_level = result_v[FRAC_BITS:0];

endmodule

FILE: src/adsr_exponential_envelope_unit.sv
// A request is registered at the input register stage and its result is then
// registered in the envelope state, which drives the output directly.
// Throughput: one request per cycle while the output is not stalled; the
// envelope level feeds back through a single multiply-add, which sets the rate.
// Reset (synchronous, active high) empties the pipeline, zeroes the level,
// sets the attack stage and loads the default configuration values.
module adsr_exponential_envelope_unit import adsr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_wen,
  input  logic [REG_IDX_W-1:0]   cfg_idx,
  input  logic [FRAC_BITS+1:0]   cfg_wdata,
  // Input requests: one per sample tick.
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   gate,
  // Output results: one per input request.
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FRAC_BITS:0]     level,
  output logic [2:0]             stage
);

  localparam int LW = FRAC_BITS + 1;   // level and unsigned target width
  localparam int TW = FRAC_BITS + 2;   // signed target width

  // Default register values are given for 16 fractional bits and are scaled
  // to the configured precision.
  localparam longint SCALE        = 64'(1) << FRAC_BITS;
  localparam longint ATTACK_RST   = (64'(103599) * SCALE) / 65536;
  localparam longint SUSTAIN_RST  = (64'(15368) * SCALE) / 65536;
  localparam longint RELEASE_RST  = -((64'(8926) * SCALE) / 65536);

  // Configuration registers.
  logic [FRAC_BITS-1:0]    rate_coeff;
  logic [LW-1:0]           attack_target;
  logic signed [TW-1:0]    decay_target;
  logic [LW-1:0]           sustain_level;
  logic signed [TW-1:0]    release_target;

  // Input register stage.
  logic                    s1_valid;
  logic                    s1_gate;
  logic                    advance;

  // Envelope state, which also serves as the output register.
  logic [LW-1:0]           env_level;
  stage_t                  env_stage;
  logic [LW-1:0]           env_level_next;
  stage_t                  env_stage_next;

  // Register writes are taken whenever the write enable is high and reset is low;
  // an index outside the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_coeff     <= FRAC_BITS'(1);
      attack_target  <= LW'(ATTACK_RST);
      decay_target   <= '0;
      sustain_level  <= LW'(SUSTAIN_RST);
      release_target <= TW'(RELEASE_RST);
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_RATE_COEFF:     rate_coeff     <= cfg_wdata[FRAC_BITS-1:0];
        REG_ATTACK_TARGET:  attack_target  <= cfg_wdata[LW-1:0];
        REG_DECAY_TARGET:   decay_target   <= signed'(cfg_wdata);
        REG_SUSTAIN_LEVEL:  sustain_level  <= cfg_wdata[LW-1:0];
        REG_RELEASE_TARGET: release_target <= signed'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // The held request moves into the envelope state once the output slot is
  // empty or being drained in this same cycle. The input register refills in
  // the same cycle, so requests stream at one per clock unless the output stalls.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_gate <= gate;
    end
  end

  adsr_step #(
    .FRAC_BITS(FRAC_BITS)
  ) u_step (
    .gate           (s1_gate),
    .cur_level      (env_level),
    .cur_stage      (env_stage),
    .rate_coeff     (rate_coeff),
    .attack_target  (attack_target),
    .decay_target   (decay_target),
    .sustain_level  (sustain_level),
    .release_target (release_target),
    .next_level     (env_level_next),
    .next_stage     (env_stage_next)
  );

  // The envelope state changes only when a request is retired, so while a
  // result waits on the output it stays put and can be shown directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      env_level <= '0;
      env_stage <= STAGE_ATTACK;
      out_valid <= 1'b0;
    end else if (advance) begin
      env_level <= env_level_next;
      env_stage <= env_stage_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign level = env_level;
  assign stage = env_stage;

  localparam logic [LW-1:0] ONE_LEVEL = {1'b1, {FRAC_BITS{1'b0}}};

  // Once killed, the envelope never leaves that stage until reset.
  assert property (@(posedge clk) disable iff (rst)
    env_stage == STAGE_KILLED |=> env_stage == STAGE_KILLED)
    else $error("killed stage was left");

  // A killed envelope always sits at zero.
  assert property (@(posedge clk) disable iff (rst)
    env_stage == STAGE_KILLED |-> env_level == '0)
    else $error("killed stage with nonzero level");

  // The level never rises above full scale outside the attack stage.
  assert property (@(posedge clk) disable iff (rst)
    env_stage != STAGE_ATTACK |-> env_level <= ONE_LEVEL)
    else $error("level above full scale");

  // Retiring a request always leaves a result on the output.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("retired request produced no result");

endmodule
